[src/chof_pkg.sv]
// Shared types and constants of the chained hash find-or-insert core.
package chof_pkg;

    // Table geometry; the bucket is the low bits of the key code.
    localparam int TABLE_SIZE = 256;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int LINK_W     = IDX_W + 1;
    localparam int KEY_W      = 21;
    localparam int SLOT_W     = 8;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_CMP,
        ST_MISS,
        ST_RESULT
    } t_state;

    // One stored entry: its code and the link to the next entry (index plus one).
    typedef struct packed {
        logic [KEY_W-1:0]  code;
        logic [LINK_W-1:0] link;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_key;
        logic head_cap;
        logic walk_start;
        logic walk_next;
        logic do_insert;
        logic res_hit;
        logic res_full;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic head_zero;
        logic code_match;
        logic next_zero;
        logic table_full;
        logic out_busy;
    } t_status;

endpackage

[src/chof_ram.sv]
// Generic single-port RAM with a registered read.
module chof_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write at the address, or read it into the output register.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/chof_ctrl.sv]
// Controller state machine of the chained hash find-or-insert core.
module chof_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  chof_pkg::t_status i_status,
    output chof_pkg::t_cmd    o_cmd
);

    chof_pkg::t_state r_state;
    chof_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chof_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands; no item is taken while reset is held.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            chof_pkg::ST_IDLE: begin
                o_ready = i_rst_n;
                if (i_valid && i_rst_n) begin
                    o_cmd.load_key = 1'b1;
                    n_state        = chof_pkg::ST_HEAD;
                end
            end
            chof_pkg::ST_HEAD: begin
                o_cmd.head_cap = 1'b1;
                if (i_status.head_zero) begin
                    n_state = chof_pkg::ST_MISS;
                end else begin
                    o_cmd.walk_start = 1'b1;
                    n_state          = chof_pkg::ST_CMP;
                end
            end
            chof_pkg::ST_CMP: begin
                if (i_status.code_match) begin
                    o_cmd.res_hit = 1'b1;
                    n_state       = chof_pkg::ST_RESULT;
                end else if (i_status.next_zero) begin
                    n_state = chof_pkg::ST_MISS;
                end else begin
                    o_cmd.walk_next = 1'b1;
                end
            end
            chof_pkg::ST_MISS: begin
                if (i_status.table_full) begin
                    o_cmd.res_full = 1'b1;
                end else begin
                    o_cmd.do_insert = 1'b1;
                end
                n_state = chof_pkg::ST_RESULT;
            end
            chof_pkg::ST_RESULT: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = chof_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = chof_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[src/chof_dpath.sv]
// Datapath: bucket heads, entry store, chain walk and output register.
module chof_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [chof_pkg::KEY_W-1:0]   i_key_code,
    input  logic                         i_ready,
    output logic                         o_valid,
    output logic [chof_pkg::SLOT_W-1:0]  o_slot_index,
    output logic                         o_was_added,
    output logic                         o_table_full,
    input  chof_pkg::t_cmd               i_cmd,
    output chof_pkg::t_status            o_status
);

    localparam int IDX_W  = chof_pkg::IDX_W;
    localparam int LINK_W = chof_pkg::LINK_W;

    logic [chof_pkg::KEY_W-1:0]  r_key;
    logic [LINK_W-1:0]           r_head_link;
    logic [IDX_W-1:0]            r_idx;
    logic [LINK_W-1:0]           r_count;
    logic [chof_pkg::TABLE_SIZE-1:0] r_hvalid;
    logic [chof_pkg::SLOT_W-1:0] r_res_slot;
    logic                        r_res_added;
    logic                        r_res_full;
    logic                        r_out_valid;
    logic [chof_pkg::SLOT_W-1:0] r_out_slot;
    logic                        r_out_added;
    logic                        r_out_full;

    logic [IDX_W-1:0]      head_addr;
    logic [LINK_W-1:0]     head_wdata;
    logic [LINK_W-1:0]     head_q;
    logic [LINK_W-1:0]     head_link;
    logic [LINK_W-1:0]     head_m1;
    logic [LINK_W-1:0]     next_m1;
    logic [IDX_W-1:0]      entry_addr;
    chof_pkg::t_entry      entry_wdata;
    chof_pkg::t_entry      entry_q;

    // Bucket head store; an unwritten bucket reads as an empty chain via its valid bit.
    assign head_addr  = i_cmd.load_key ? i_key_code[IDX_W-1:0] : r_key[IDX_W-1:0];
    assign head_wdata = r_count + LINK_W'(1);

    chof_ram #(
        .WIDTH (LINK_W),
        .DEPTH (chof_pkg::TABLE_SIZE)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.do_insert),
        .i_addr  (head_addr),
        .i_wdata (head_wdata),
        .o_rdata (head_q)
    );

    assign head_link = r_hvalid[r_key[IDX_W-1:0]] ? head_q : '0;
    assign head_m1   = head_link - LINK_W'(1);
    assign next_m1   = entry_q.link - LINK_W'(1);

    // Entry store: written on insert, read once per chain step.
    always_comb begin
        if (i_cmd.do_insert) begin
            entry_addr = r_count[IDX_W-1:0];
        end else if (i_cmd.walk_next) begin
            entry_addr = next_m1[IDX_W-1:0];
        end else begin
            entry_addr = head_m1[IDX_W-1:0];
        end
    end

    assign entry_wdata.code = r_key;
    assign entry_wdata.link = r_head_link;

    chof_ram #(
        .WIDTH ($bits(chof_pkg::t_entry)),
        .DEPTH (chof_pkg::TABLE_SIZE)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.do_insert),
        .i_addr  (entry_addr),
        .i_wdata (entry_wdata),
        .o_rdata (entry_q)
    );

    // Control state: entry count, head valid bits and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_hvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.do_insert) begin
                r_count                     <= r_count + LINK_W'(1);
                r_hvalid[r_key[IDX_W-1:0]]  <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: key, walk position and the pending result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_key) begin
            r_key <= i_key_code;
        end
        if (i_cmd.head_cap) begin
            r_head_link <= head_link;
        end
        if (i_cmd.walk_start) begin
            r_idx <= head_m1[IDX_W-1:0];
        end else if (i_cmd.walk_next) begin
            r_idx <= next_m1[IDX_W-1:0];
        end
        if (i_cmd.res_hit) begin
            r_res_slot  <= chof_pkg::SLOT_W'(r_idx);
            r_res_added <= 1'b0;
            r_res_full  <= 1'b0;
        end else if (i_cmd.do_insert) begin
            r_res_slot  <= chof_pkg::SLOT_W'(r_count[IDX_W-1:0]);
            r_res_added <= 1'b1;
            r_res_full  <= 1'b0;
        end else if (i_cmd.res_full) begin
            r_res_slot  <= '0;
            r_res_added <= 1'b0;
            r_res_full  <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_slot  <= r_res_slot;
            r_out_added <= r_res_added;
            r_out_full  <= r_res_full;
        end
    end

    // Status toward the controller.
    assign o_status.head_zero  = (head_link == '0);
    assign o_status.code_match = (entry_q.code == r_key);
    assign o_status.next_zero  = (entry_q.link == '0);
    assign o_status.table_full = (r_count == LINK_W'(chof_pkg::TABLE_SIZE));
    assign o_status.out_busy   = r_out_valid && !i_ready;

    assign o_valid      = r_out_valid;
    assign o_slot_index = r_out_slot;
    assign o_was_added  = r_out_added;
    assign o_table_full = r_out_full;

`ifndef SYNTH
    // The entry count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LINK_W'(chof_pkg::TABLE_SIZE))
        else $error("entry count beyond capacity");

    // An insert is only issued while a free entry remains.
    a_insert_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_insert |-> !o_status.table_full)
        else $error("insert into a full table");

    // Each insert adds exactly one entry.
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_insert |=> r_count == $past(r_count) + LINK_W'(1))
        else $error("entry count did not advance on insert");

    // A delivered item never reports both an insert and a full table.
    a_result_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_added && r_out_full))
        else $error("added and full set together");
`endif

endmodule

[src/chained_hash_find_or_insert_core.sv]
// Chained hash find-or-insert core: top level joining controller and datapath.
//
// Each accepted item carries one key code; the block looks it up in a chained
// hash table of TABLE_SIZE entries (bucket = low bits of the code) and returns
// one result item: the entry index with was_added clear on a hit, or a newly
// appended entry linked at the head of its bucket with was_added set. A miss on
// a full table returns slot 0 with table_full set and stores nothing. One item
// is worked at a time: after acceptance the block reads the bucket head, then
// walks the chain comparing each stored code with the key; a hit loads its
// result, and a miss at the end of the chain first inserts the entry (or notes
// a full table) and then loads its result. The chain walk reads one entry per
// cycle from the single-port entry RAM. The result sits in an output register,
// so the block returns to accepting items as soon as the result has moved into
// that register. Bucket heads are valid immediately after reset through one
// valid bit per bucket; no clearing pass is needed.
module chained_hash_find_or_insert_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [chof_pkg::KEY_W-1:0]  i_key_code,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [chof_pkg::SLOT_W-1:0] o_slot_index,
    output logic                        o_was_added,
    output logic                        o_table_full
);

    chof_pkg::t_cmd    cmd;
    chof_pkg::t_status status;

    // Sequencer for the lookup, walk and insert steps.
    chof_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Table storage, comparison and result registers.
    chof_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key_code   (i_key_code),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_slot_index (o_slot_index),
        .o_was_added  (o_was_added),
        .o_table_full (o_table_full),
        .i_cmd        (cmd),
        .o_status     (status)
    );

endmodule
